// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk, except while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check prop on every rising edge of clk, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/fp64rem_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp64rem_pkg
// Types and constants for the binary64 remainder unit.
// ----------------------------------------------------------------------------
package fp64rem_pkg;

   localparam logic [63:0] SignMask   = 64'h8000_0000_0000_0000;
   localparam logic [10:0] ExpAllOnes = 11'h7FF;
   localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;
   localparam logic [63:0] DefaultNan = 64'h7FF8_0000_0000_0000;
   localparam int          ExpW       = 13;
   localparam int          CntW       = 12;
   localparam int          ManW       = 53;
   localparam int          RemW       = 56;

   typedef struct packed {
      logic [63:0] x_bits;
      logic [63:0] y_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] rem_bits;
      logic        invalid;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM_X,
      ST_NORM_Y,
      ST_DIV,
      ST_FIX,
      ST_NORM_L,
      ST_NORM_R
   } state_type;

endpackage

// ----- rtl/core/fp64_ieee_remainder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp64_ieee_remainder
// Exact IEEE 754 binary64 remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
// Sequence: special operands are answered straight from idle; otherwise the
//   sequencer normalises subnormal operands, runs the shift-subtract loop
//   over the exponent difference, fixes the quotient rounding and normalises
//   the result. One transaction at a time; busy is high while it runs.
// Reset: synchronous, active high; returns the sequencer to idle, no result.
// The receiver cannot stall: rsp_valid marks a result for one cycle.
`include "assert_macros.svh"

module fp64_ieee_remainder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fp64rem_pkg::req_type req_data,
   output logic                 rsp_valid,
   output fp64rem_pkg::rsp_type rsp_data
);

   localparam int ExpW = fp64rem_pkg::ExpW;
   localparam int CntW = fp64rem_pkg::CntW;
   localparam int ManW = fp64rem_pkg::ManW;
   localparam int RemW = fp64rem_pkg::RemW;

   fp64rem_pkg::state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fp64rem_pkg::rsp_type   rsp_ff, rsp_in;
   logic [63:0]            x_ff, x_in;
   logic [ManW-1:0]        mx_ff, mx_in, my_ff, my_in;
   logic signed [ExpW-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [RemW-1:0]        r_ff, r_in;
   logic [CntW-1:0]        k_ff, k_in;
   logic                   q_ff, q_in;
   logic                   sgn_ff, sgn_in;

   logic                   x_nan, y_nan, x_snan, y_snan, special;
   logic [62:0]            ax, ay;
   logic [RemW-1:0]        my_ext, my2_ext, diff;
   logic                   ge;
   logic                   div_active;

   assign ax     = req_data.x_bits[62:0];
   assign ay     = req_data.y_bits[62:0];
   assign x_nan  = (ax[62:52] == fp64rem_pkg::ExpAllOnes) && (ax[51:0] != 52'd0);
   assign y_nan  = (ay[62:52] == fp64rem_pkg::ExpAllOnes) && (ay[51:0] != 52'd0);
   assign x_snan = x_nan && !req_data.x_bits[51];
   assign y_snan = y_nan && !req_data.y_bits[51];
   assign special = x_nan || y_nan || (ax[62:52] == fp64rem_pkg::ExpAllOnes)
                    || (ay == 63'd0) || (ay[62:52] == fp64rem_pkg::ExpAllOnes)
                    || (ax == 63'd0);

   assign my_ext  = {{(RemW-ManW){1'b0}}, my_ff};
   assign my2_ext = {{(RemW-ManW-1){1'b0}}, my_ff, 1'b0};
   assign ge      = (r_ff >= my_ext);
   assign diff    = ge ? (r_ff - my_ext) : r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fp64rem_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      x_ff   <= x_in;
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      ex_ff  <= ex_in;
      ey_ff  <= ey_in;
      r_ff   <= r_in;
      k_ff   <= k_in;
      q_ff   <= q_in;
      sgn_ff <= sgn_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      x_in         = x_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      q_in         = q_ff;
      sgn_in       = sgn_ff;
      case (state_ff)
         fp64rem_pkg::ST_IDLE: begin
            if (start) begin
               x_in   = req_data.x_bits;
               sgn_in = req_data.x_bits[63];
               mx_in  = {(ax[62:52] != 11'd0), ax[51:0]};
               my_in  = {(ay[62:52] != 11'd0), ay[51:0]};
               ex_in  = (ax[62:52] == 11'd0) ? ExpW'(1) : ExpW'({2'b00, ax[62:52]});
               ey_in  = (ay[62:52] == 11'd0) ? ExpW'(1) : ExpW'({2'b00, ay[62:52]});
               if (x_nan || y_nan) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.invalid  = x_snan || y_snan;
                  rsp_in.rem_bits = x_nan ? (req_data.x_bits | fp64rem_pkg::QuietBit)
                                          : (req_data.y_bits | fp64rem_pkg::QuietBit);
               end else if ((ax[62:52] == fp64rem_pkg::ExpAllOnes) || (ay == 63'd0)) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.invalid  = 1'b1;
                  rsp_in.rem_bits = fp64rem_pkg::DefaultNan;
               end else if (special) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.invalid  = 1'b0;
                  rsp_in.rem_bits = req_data.x_bits;
               end else begin
                  state_in = fp64rem_pkg::ST_NORM_X;
               end
            end
         end
         fp64rem_pkg::ST_NORM_X: begin
            if (mx_ff[ManW-1]) begin
               state_in = fp64rem_pkg::ST_NORM_Y;
            end else begin
               mx_in = {mx_ff[ManW-2:0], 1'b0};
               ex_in = ex_ff - ExpW'(1);
            end
         end
         fp64rem_pkg::ST_NORM_Y: begin
            if (!my_ff[ManW-1]) begin
               my_in = {my_ff[ManW-2:0], 1'b0};
               ey_in = ey_ff - ExpW'(1);
            end else if (ex_ff < ey_ff - ExpW'(1)) begin
               rsp_valid_in    = 1'b1;
               rsp_in.invalid  = 1'b0;
               rsp_in.rem_bits = x_ff;
               state_in        = fp64rem_pkg::ST_IDLE;
            end else if (ex_ff == ey_ff - ExpW'(1)) begin
               r_in     = {{(RemW-ManW){1'b0}}, mx_ff};
               q_in     = 1'b0;
               state_in = fp64rem_pkg::ST_FIX;
            end else begin
               r_in     = {{(RemW-ManW){1'b0}}, mx_ff};
               k_in     = CntW'(ex_ff - ey_ff);
               state_in = fp64rem_pkg::ST_DIV;
            end
         end
         fp64rem_pkg::ST_DIV: begin
            q_in = ge;
            r_in = {diff[RemW-2:0], 1'b0};
            if (k_ff == CntW'(0)) begin
               state_in = fp64rem_pkg::ST_FIX;
            end else begin
               k_in = k_ff - CntW'(1);
            end
         end
         fp64rem_pkg::ST_FIX: begin
            ex_in = ey_ff - ExpW'(1);
            if ((r_ff > my_ext) || ((r_ff == my_ext) && q_ff)) begin
               r_in   = my2_ext - r_ff;
               sgn_in = !sgn_ff;
            end
            state_in = fp64rem_pkg::ST_NORM_L;
         end
         fp64rem_pkg::ST_NORM_L: begin
            if (r_ff == RemW'(0)) begin
               rsp_valid_in    = 1'b1;
               rsp_in.invalid  = 1'b0;
               rsp_in.rem_bits = x_ff & fp64rem_pkg::SignMask;
               state_in        = fp64rem_pkg::ST_IDLE;
            end else if (!r_ff[ManW-1] && (ex_ff > ExpW'(1))) begin
               r_in  = {r_ff[RemW-2:0], 1'b0};
               ex_in = ex_ff - ExpW'(1);
            end else begin
               state_in = fp64rem_pkg::ST_NORM_R;
            end
         end
         fp64rem_pkg::ST_NORM_R: begin
            if (ex_ff < ExpW'(1)) begin
               r_in  = {1'b0, r_ff[RemW-1:1]};
               ex_in = ex_ff + ExpW'(1);
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_in.invalid = 1'b0;
               if (r_ff[ManW-1]) begin
                  rsp_in.rem_bits = {sgn_ff, ex_ff[10:0], r_ff[51:0]};
               end else begin
                  rsp_in.rem_bits = {sgn_ff, 11'd0, r_ff[51:0]};
               end
               state_in = fp64rem_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fp64rem_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != fp64rem_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign div_active = (state_ff == fp64rem_pkg::ST_DIV);

   `ASSERT_CLK(a_rsp_idle, clock, reset, rsp_valid_ff |-> !busy, "result while busy")
   `ASSERT_CLK(a_start_seq, clock, reset, start && !busy && !special |=> busy, "no start")
   `ASSERT_CLK(a_start_quiet, clock, reset, start && !busy && !special |=> !rsp_valid_ff, "early")
   `ASSERT_CLK(a_div_bound, clock, reset, div_active |-> (r_ff < my2_ext), "remainder range")

endmodule

// ----- verif/fp64_ieee_remainder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp64_ieee_remainder_tb
// Self-checking bench for the binary64 remainder unit: directed special
// operands, ties, subnormals and extreme exponent gaps, then random operand
// pairs under three start-gap regimes, each result checked against an exact
// bit-level shift-subtract remainder computed in the bench.
// ----------------------------------------------------------------------------
module fp64_ieee_remainder_tb;

   localparam logic [63:0] ExpField  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] FracField = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] HiddenBit = 64'h0010_0000_0000_0000;
   localparam longint      CycleLimit = 3_000_000;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   fp64rem_pkg::req_type req_data;
   logic                 rsp_valid;
   fp64rem_pkg::rsp_type rsp_data;

   fp64rem_pkg::rsp_type expected_rems[$];
   int                   errors;
   int                   start_gap_pct;
   longint               cycles;

   fp64_ieee_remainder dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic logic is_nan64(logic [63:0] b);
      return (b[62:52] == fp64rem_pkg::ExpAllOnes) && (b[51:0] != 52'd0);
   endfunction

   function automatic fp64rem_pkg::rsp_type ieee_rem(logic [63:0] x, logic [63:0] y);
      fp64rem_pkg::rsp_type r;
      logic [63:0]          ax, ay, mx, my, part, wide, sgn;
      int                   ex, ey, k, e;
      logic                 qbit;
      ax = x & ~fp64rem_pkg::SignMask;
      ay = y & ~fp64rem_pkg::SignMask;
      r.invalid = 1'b0;
      qbit = 1'b0;
      if (is_nan64(x) || is_nan64(y)) begin
         r.invalid = (is_nan64(x) && !x[51]) || (is_nan64(y) && !y[51]);
         r.rem_bits = is_nan64(x) ? (x | fp64rem_pkg::QuietBit)
                                  : (y | fp64rem_pkg::QuietBit);
      end else if (ax == ExpField || ay == 64'd0) begin
         r.invalid = 1'b1;
         r.rem_bits = fp64rem_pkg::DefaultNan;
      end else if (ay == ExpField || ax == 64'd0) begin
         r.rem_bits = x;
      end else begin
         sgn = x & fp64rem_pkg::SignMask;
         ex = int'(x[62:52]); mx = x & FracField;
         if (ex == 0) ex = 1; else mx |= HiddenBit;
         while ((mx & HiddenBit) == 64'd0) begin mx <<= 1; ex--; end
         ey = int'(y[62:52]); my = y & FracField;
         if (ey == 0) ey = 1; else my |= HiddenBit;
         while ((my & HiddenBit) == 64'd0) begin my <<= 1; ey--; end
         if (ex < ey - 1) begin
            r.rem_bits = x;
         end else begin
            if (ex == ey - 1) begin
               wide = mx;
            end else begin
               part = mx;
               for (k = ex - ey; k >= 0; k--) begin
                  if (part >= my) begin part -= my; qbit = 1'b1; end
                  else qbit = 1'b0;
                  if (k != 0) part <<= 1;
               end
               wide = part << 1;
            end
            if (wide > my || (wide == my && qbit)) begin
               wide = (my << 1) - wide;
               sgn ^= fp64rem_pkg::SignMask;
            end
            if (wide == 64'd0) begin
               r.rem_bits = x & fp64rem_pkg::SignMask;
            end else begin
               e = ey - 1;
               while (wide < HiddenBit && e > 1) begin wide <<= 1; e--; end
               while (e < 1) begin wide >>= 1; e++; end
               if (wide >= HiddenBit)
                  r.rem_bits = sgn | (64'(e) << 52) | (wide & FracField);
               else
                  r.rem_bits = sgn | wide;
            end
         end
      end
      return r;
   endfunction

   task automatic send_operands(logic [63:0] x, logic [63:0] y);
      if ($urandom_range(99) < start_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < start_gap_pct) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{x_bits: x, y_bits: y};
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rems.push_back(ieee_rem(x, y));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rems.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h/%b", $time, rsp_data.rem_bits,
                     rsp_data.invalid);
         end else begin
            fp64rem_pkg::rsp_type want;
            want = expected_rems.pop_front();
            if (want.rem_bits !== rsp_data.rem_bits) begin
               errors++;
               $display("%0t: rem_bits expected %h actual %h", $time,
                        want.rem_bits, rsp_data.rem_bits);
            end
            if (want.invalid !== rsp_data.invalid) begin
               errors++;
               $display("%0t: invalid expected %b actual %b", $time,
                        want.invalid, rsp_data.invalid);
            end
         end
      end
   end

   function automatic logic [63:0] make_double(logic s, int ex);
      return {s, 11'(ex), $urandom(), 20'($urandom())};
   endfunction

   task automatic test_special_operands();
      send_operands(64'h7FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000);
      send_operands(64'h3FF0_0000_0000_0000, 64'hFFF4_0000_0000_0000);
      send_operands(64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001);
      send_operands(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send_operands(64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
      send_operands(64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000);
      send_operands(64'hC008_0000_0000_0000, 64'hFFF0_0000_0000_0000);
      send_operands(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
      send_operands(64'h0, 64'h0000_0000_0000_0001);
   endtask

   task automatic test_ties_and_exact();
      send_operands(64'h4014_0000_0000_0000, 64'h4000_0000_0000_0000);
      send_operands(64'h400C_0000_0000_0000, 64'h4000_0000_0000_0000);
      send_operands(64'hC018_0000_0000_0000, 64'h4008_0000_0000_0000);
      send_operands(64'h3FE0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
      send_operands(64'h3FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000);
   endtask

   task automatic test_extreme_exponents();
      send_operands(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
      send_operands(64'h7FEF_FFFF_FFFF_FFFF, 64'h000F_FFFF_FFFF_FFFF);
      send_operands(64'h0000_0000_0000_0003, 64'h0000_0000_0000_0002);
      send_operands(64'h800F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0007);
      send_operands(64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF);
      send_operands(64'h7FE0_0000_0000_0001, 64'h0010_0000_0000_0001);
      send_operands(64'h3FF0_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_random_operands(int count);
      int          sel, ey, ex;
      logic [63:0] x, y;
      repeat (count) begin
         sel = int'($urandom_range(99));
         ey  = int'($urandom_range(2046));
         y   = make_double(1'($urandom()), ey);
         if (sel < 60) begin
            ex = ey + int'($urandom_range(60));
            x = make_double(1'($urandom()), (ex < 2046) ? ex : ey);
         end else if (sel < 70) begin
            x = make_double(1'($urandom()), int'($urandom_range(2046)));
         end else if (sel < 80) begin
            x = make_double(1'($urandom()), ($urandom_range(1) != 0) ? 0 : 2047);
            y = make_double(1'($urandom()), ($urandom_range(1) != 0) ? 0 : 2047);
         end else if (sel < 90) begin
            x = {$urandom(), $urandom()};
            y = {$urandom(), $urandom()};
         end else begin
            x = make_double(1'($urandom()), int'($urandom_range(2046)));
            y = {1'($urandom()), 63'(0)}
                | (($urandom_range(3) == 0) ? ExpField : 64'h0);
         end
         send_operands(x, y);
      end
   endtask

   initial begin
      errors = 0;
      start_gap_pct = 19;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_operands();
      test_ties_and_exact();
      test_extreme_exponents();
      test_random_operands(90);
      start_gap_pct = 64;
      test_random_operands(90);
      start_gap_pct = 0;
      test_random_operands(80);
      start <= 1'b0;
      while (expected_rems.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_rems.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
